>>> hdl/pbd_pkg.sv
// shared constants and stage payload types for the parallel bit deposit unit
package pbd_pkg;

  localparam int FIELD_WIDTH = 64;
  localparam int WORD_WIDTH  = 64;
  localparam int GROUP_WIDTH = 8;
  localparam int NUM_GROUPS  = (WORD_WIDTH + GROUP_WIDTH - 1) / GROUP_WIDTH;
  localparam int PAD_WIDTH   = NUM_GROUPS * GROUP_WIDTH;
  localparam int RANK_W      = $clog2(WORD_WIDTH);
  localparam int SUM_W       = RANK_W + 1;
  localparam int LOCAL_W     = $clog2(GROUP_WIDTH);
  localparam int GCNT_W      = $clog2(GROUP_WIDTH + 1);

  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef logic [WORD_WIDTH-1:0]  word_t;
  typedef logic [PAD_WIDTH-1:0]   pad_word_t;

  typedef struct packed {
    pad_word_t                            mask;
    word_t                                src;
    logic [PAD_WIDTH-1:0][LOCAL_W-1:0]    local_rank;
    logic [NUM_GROUPS-1:0][GCNT_W-1:0]    group_cnt;
  } count_stage_t;

  typedef struct packed {
    pad_word_t                            mask;
    word_t                                src;
    logic [PAD_WIDTH-1:0][LOCAL_W-1:0]    local_rank;
    logic [NUM_GROUPS-1:0][RANK_W-1:0]    offset;
    logic [GCNT_W-1:0]                    last_cnt;
  } offset_stage_t;

endpackage

>>> hdl/parallel_bit_deposit_unit.sv
// top level of the pipelined parallel bit deposit unit
//
// s_axis carries one request per beat: tdata[63:0] is select_mask and
// tdata[127:64] is source_bits. m_axis returns one 64-bit deposited word
// per request, in request order.
// The k-th set bit of the mask (counted from the least significant end)
// appears in the result when bit k of the source is one; all other result
// bits are zero.
// The result passes four register stages, the first loaded at the accepting
// edge: group counting, group offset sum, per-bit rank add, source bit
// select; m_axis_tvalid rises once the last stage holds the result.
// Throughput is one request per cycle while m_axis takes results; the widest step is the 64-way
// source bit select in the last stage.
// Each stage holds its own valid bit and takes a new request whenever it
// is empty or its content moves on, so s_axis_tready stays high while the
// pipeline has room even if m_axis is stalled.
// When m_axis_tready is low the result holds on m_axis and requests fill
// the pipeline until all four stages are full; then s_axis_tready drops.
// Synchronous reset empties all stages; no request survives it.
module parallel_bit_deposit_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // select_mask [63:0], source_bits [127:64]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata    // deposited [63:0]
);

  logic                    cnt_valid;
  logic                    cnt_ready;
  pbd_pkg::count_stage_t   cnt_data;
  logic                    off_valid;
  logic                    off_ready;
  pbd_pkg::offset_stage_t  off_data;
  pbd_pkg::word_t          result;

  pbd_count u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mask   (s_axis_tdata[63:0]),
    .in_src    (s_axis_tdata[127:64]),
    .out_valid (cnt_valid),
    .out_ready (cnt_ready),
    .out_data  (cnt_data)
  );

  pbd_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cnt_valid),
    .in_ready  (cnt_ready),
    .in_data   (cnt_data),
    .out_valid (off_valid),
    .out_ready (off_ready),
    .out_data  (off_data)
  );

  pbd_select u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (off_valid),
    .in_ready   (off_ready),
    .in_data    (off_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // result is cast to FIELD_WIDTH; any bits above WORD_WIDTH are zero
  assign m_axis_tdata = pbd_pkg::FIELD_WIDTH'(result);

endmodule

>>> hdl/pbd_count.sv
// first stage: per-group set-bit counts and in-group ranks of each mask bit
module pbd_count (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pbd_pkg::field_t         in_mask,
  input  pbd_pkg::field_t         in_src,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pbd_pkg::count_stage_t   out_data
);

  logic                      vld;
  pbd_pkg::count_stage_t     data;
  pbd_pkg::count_stage_t     data_next;

  always_comb begin
    logic [pbd_pkg::GCNT_W-1:0] run;
    run = '0;
    data_next.mask = pbd_pkg::PAD_WIDTH'(in_mask[pbd_pkg::WORD_WIDTH-1:0]);
    data_next.src  = in_src[pbd_pkg::WORD_WIDTH-1:0];
    data_next.local_rank = '0;
    data_next.group_cnt  = '0;
    for (int g = 0; g < pbd_pkg::NUM_GROUPS; g++) begin
      run = '0;
      for (int j = 0; j < pbd_pkg::GROUP_WIDTH; j++) begin
        data_next.local_rank[g*pbd_pkg::GROUP_WIDTH + j] = pbd_pkg::LOCAL_W'(run);
        run = run + pbd_pkg::GCNT_W'(data_next.mask[g*pbd_pkg::GROUP_WIDTH + j]);
      end
      data_next.group_cnt[g] = run;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  for (genvar g = 0; g < pbd_pkg::NUM_GROUPS; g++) begin : g_chk
    a_group_cnt: assert property (@(posedge clk) disable iff (rst)
      vld |-> (int'(data.group_cnt[g]) ==
               $countones(data.mask[g*pbd_pkg::GROUP_WIDTH +: pbd_pkg::GROUP_WIDTH])))
      else $error("group count does not match mask group");
  end

endmodule

>>> hdl/pbd_offset.sv
// second stage: running sum of group counts gives the rank offset of each group
module pbd_offset (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pbd_pkg::count_stage_t   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pbd_pkg::offset_stage_t  out_data
);

  logic                      vld;
  pbd_pkg::offset_stage_t    data;
  pbd_pkg::offset_stage_t    data_next;

  always_comb begin
    logic [pbd_pkg::SUM_W-1:0] acc;
    acc = '0;
    data_next.mask       = in_data.mask;
    data_next.src        = in_data.src;
    data_next.local_rank = in_data.local_rank;
    data_next.offset     = '0;
    for (int g = 0; g < pbd_pkg::NUM_GROUPS; g++) begin
      data_next.offset[g] = pbd_pkg::RANK_W'(acc);
      acc = acc + pbd_pkg::SUM_W'(in_data.group_cnt[g]);
    end
    data_next.last_cnt = in_data.group_cnt[pbd_pkg::NUM_GROUPS-1];
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  // last offset plus last group count must cover every set mask bit
  a_total: assert property (@(posedge clk) disable iff (rst)
    vld |-> (int'(data.offset[pbd_pkg::NUM_GROUPS-1]) + int'(data.last_cnt) ==
             $countones(data.mask)))
    else $error("group offsets do not add up to mask population");

endmodule

>>> hdl/pbd_select.sv
// third and fourth stages: full rank per mask bit, then pick the source bit
module pbd_select (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pbd_pkg::offset_stage_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pbd_pkg::word_t          out_result
);

  logic                                               vld_rank;
  logic                                               vld_out;
  logic                                               rdy_rank;
  logic                                               rdy_out;
  logic [pbd_pkg::PAD_WIDTH-1:0][pbd_pkg::RANK_W-1:0] rank;
  logic [pbd_pkg::PAD_WIDTH-1:0][pbd_pkg::RANK_W-1:0] rank_next;
  pbd_pkg::word_t                                     mask_rank;
  pbd_pkg::word_t                                     src_rank;
  pbd_pkg::word_t                                     mask_out;
  pbd_pkg::word_t                                     src_out;
  pbd_pkg::word_t                                     result;
  pbd_pkg::word_t                                     result_next;

  always_comb begin
    for (int i = 0; i < pbd_pkg::PAD_WIDTH; i++) begin
      rank_next[i] = in_data.offset[i / pbd_pkg::GROUP_WIDTH] +
                     pbd_pkg::RANK_W'(in_data.local_rank[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < pbd_pkg::WORD_WIDTH; i++) begin
      result_next[i] = mask_rank[i] & src_rank[rank[i]];
    end
  end

  assign rdy_out    = !vld_out || out_ready;
  assign rdy_rank   = !vld_rank || rdy_out;
  assign in_ready   = rdy_rank;
  assign out_valid  = vld_out;
  assign out_result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_rank <= 1'b0;
      vld_out  <= 1'b0;
    end else begin
      if (rdy_rank) begin
        vld_rank <= in_valid;
      end
      if (rdy_out) begin
        vld_out <= vld_rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_rank && in_valid) begin
      rank      <= rank_next;
      mask_rank <= in_data.mask[pbd_pkg::WORD_WIDTH-1:0];
      src_rank  <= in_data.src;
    end
    if (rdy_out && vld_rank) begin
      result   <= result_next;
      mask_out <= mask_rank;
      src_out  <= src_rank;
    end
  end

  a_in_mask: assert property (@(posedge clk) disable iff (rst)
    vld_out |-> ((result & ~mask_out) == '0))
    else $error("result bit set outside the mask");

  a_no_source: assert property (@(posedge clk) disable iff (rst)
    (vld_out && (src_out == '0)) |-> (result == '0))
    else $error("non-zero result from an all-zero source");

endmodule

>>> tb/pbd_checker.sv
// scoreboard for the parallel bit deposit unit: predicts each deposited word and compares it
module pbd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int           error_count,
  output int           pending,
  output int           checked
);
  timeunit 1ns;
  timeprecision 1ps;

  pbd_pkg::field_t expected_deposits[$];
  int              errors = 0;
  int              results_seen = 0;

  // only the low WORD_WIDTH mask bits take part; source bit k feeds the k-th set mask bit
  function automatic pbd_pkg::field_t deposit_select_bits(pbd_pkg::field_t sel,
                                                          pbd_pkg::field_t src);
    pbd_pkg::field_t res;
    int              k;
    res = '0;
    k   = 0;
    for (int i = 0; i < pbd_pkg::WORD_WIDTH; i++) begin
      if (sel[i]) begin
        if (src[k]) res[i] = 1'b1;
        k++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pbd_pkg::field_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_deposits.push_back(deposit_select_bits(s_axis_tdata[63:0], s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_deposits.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result %h with no request outstanding", $realtime,
                     m_axis_tdata);
        end else begin
          want = expected_deposits.pop_front();
          if (m_axis_tdata !== want) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] deposited mismatch: expected %h, got %h", $realtime, want,
                       m_axis_tdata);
          end
        end
      end
    end
    error_count <= errors;
    pending     <= expected_deposits.size();
    checked     <= results_seen;
  end

endmodule

>>> tb/tb_parallel_bit_deposit_unit.sv
// stimulus and verdict for the parallel bit deposit unit, with the scoreboard alongside
module tb_parallel_bit_deposit_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 900;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKED, RX_CADENCE} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;

  int       error_count;
  int       pending;
  int       checked;
  int       sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       rx_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  parallel_bit_deposit_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pbd_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .error_count  (error_count),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver picks one of four stall modes at random whenever its current mode runs out
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    unique case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_CHOKED:  m_axis_tready <= ($urandom_range(0, 7) == 0);
      RX_CADENCE: m_axis_tready <= (rx_tick % 5) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT,
                 pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one request, then either carry on with the burst or drop tvalid for a random gap
  task automatic send_request(pbd_pkg::field_t mask, pbd_pkg::field_t src);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {src, mask};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic pbd_pkg::field_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic pbd_pkg::field_t rand_mask();
    pbd_pkg::field_t m;
    int              lo;
    int              hi;
    case ($urandom_range(0, 5))
      0: m = rand_word() & rand_word() & rand_word();
      1: m = rand_word() | rand_word() | rand_word();
      2: begin
        lo = $urandom_range(0, 63);
        hi = $urandom_range(lo, 63);
        m  = '0;
        for (int i = lo; i <= hi; i++) m[i] = 1'b1;
      end
      3: m = pbd_pkg::field_t'(1) << $urandom_range(0, 63);
      default: m = rand_word();
    endcase
    return m;
  endfunction

  function automatic pbd_pkg::field_t rand_source();
    pbd_pkg::field_t s;
    case ($urandom_range(0, 4))
      0: s = pbd_pkg::field_t'($urandom_range(0, 255));
      1: s = ~rand_word() | rand_word();
      default: s = rand_word();
    endcase
    return s;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty mask, full mask, single end bits and surplus source bits
    send_request(64'h0, 64'h0);
    send_request(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
    send_request(64'h1, 64'h1);
    send_request(64'h1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(64'h8000_0000_0000_0000, 64'h1);
    send_request(64'h8000_0000_0000_0000, 64'h2);
    send_request(64'hF0F0_F0F0_F0F0_F0F0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_0000_0000);
    send_request(64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FF00);
    send_request(64'hFF00_0000_0000_0000, 64'h0000_0000_0000_000F);
    send_request(64'h8000_0000_0000_0001, 64'h3);
    send_request(64'h5555_5555_5555_5555, 64'h1234_5678_9ABC_DEF0);
    send_request(64'hFFFF_0000_0000_FFFF, 64'hC3A5_0F96_7E18_24DB);

    for (int n = 0; n < RANDOM_REQUESTS; n++)
      send_request(rand_mask(), rand_source());
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests (18 directed edge cases, the rest random masks of mixed density)",
             sent);
    $display("compared %0d deposited words under bursty input and varying output back-pressure",
             checked);
    if (error_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
